// ----- hdl/lz77d_pkg.sv -----
// Shared types and constants for the LZ77 triple decoder.
package lz77d_pkg;

  localparam int WINDOW_DEF     = 4096;
  localparam int MAX_LENGTH_DEF = 63;

  localparam int OFFSET_W = 13;
  localparam int LENGTH_W = 6;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] NO_LITERAL = '0;

  typedef struct packed {
    logic                first_token;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [BYTE_W-1:0]   next_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              bad_offset;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_LIT,
    ST_ERR
  } state_t;

endpackage

// ----- hdl/lz77d_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module lz77d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lz77_triple_decoder_core.sv -----
// LZ77 triple decoder: expands (offset, length, next byte) tokens into bytes.
//
//  channel | ports                          | word
//  --------+--------------------------------+------------------------------------
//  input   | in_valid, in_ready, in_word    | first_token, offset, length, next_byte
//  output  | out_valid, out_ready, out_word | out_byte, last, bad_offset
//
// A token is taken only in idle; the first copied byte is read from the registered
// history RAM in the cycle after, then one byte a cycle while the output is not
// stalled, then the literal if there is one; a bad offset gives one error word.
// After its first byte, a distance-one copy is served from the byte just written, not from the RAM.
// Output stalls freeze the copy in place; the output register holds one word.
// Reset clears state, output valid, write pointer and fill count only; history is never cleared.
module lz77_triple_decoder_core #(
  parameter int WINDOW     = lz77d_pkg::WINDOW_DEF,
  parameter int MAX_LENGTH = lz77d_pkg::MAX_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lz77d_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lz77d_pkg::out_word_t out_word
);

  import lz77d_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int BW = $clog2(WINDOW + 1);
  localparam int CW = (AW + 1 > OFFSET_W) ? AW + 1 : OFFSET_W;
  localparam logic [AW-1:0]       WP_LAST  = AW'(WINDOW - 1);
  localparam logic [BW-1:0]       BW_FULL  = BW'(WINDOW);
  localparam logic [CW-1:0]       WIN_EXT  = CW'(WINDOW);
  localparam logic [LENGTH_W-1:0] LEN_MAX  = LENGTH_W'(MAX_LENGTH);

  state_t state_r, state_nxt;

  logic [AW-1:0]       wp_r, wp_nxt;
  logic [BW-1:0]       bw_r, bw_nxt;
  logic [AW-1:0]       src_r, src_nxt;
  logic [LENGTH_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   lit_r, lit_nxt;
  logic                off1_r, off1_nxt;
  logic                first_r, first_nxt;
  logic [BYTE_W-1:0]   hold_r, hold_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic              in_fire;
  logic              slot_free;
  logic [AW-1:0]     wp_eff;
  logic [BW-1:0]     bw_eff;
  logic [LENGTH_W-1:0] len_clamp;
  logic [CW-1:0]     off_ext;
  logic [CW-1:0]     wp_ext;
  logic [CW-1:0]     src_full;
  logic              tok_bad;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     src_inc;
  logic [BW-1:0]     bw_inc;
  logic [BYTE_W-1:0] copy_byte;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // token decode, done on the incoming word in idle
  always_comb begin
    wp_eff    = in_word.first_token ? '0 : wp_r;
    bw_eff    = in_word.first_token ? '0 : bw_r;
    len_clamp = (in_word.length > LEN_MAX) ? LEN_MAX : in_word.length;
    off_ext   = CW'(in_word.offset);
    wp_ext    = CW'(wp_eff);
    tok_bad   = (len_clamp != '0) &&
                ((in_word.offset == '0) || (off_ext > WIN_EXT) ||
                 (off_ext > CW'(bw_eff)));
    src_full  = (wp_ext >= off_ext) ? (wp_ext - off_ext) : (wp_ext + WIN_EXT - off_ext);
  end

  assign wp_inc    = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
  assign src_inc   = (src_r == WP_LAST) ? '0 : src_r + 1'b1;
  assign bw_inc    = (bw_r == BW_FULL) ? bw_r : bw_r + 1'b1;
  // distance one: every copied byte repeats the one just written
  assign copy_byte = (off1_r && !first_r) ? hold_r : ram_rdata;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (tok_bad) begin
            state_nxt = ST_ERR;
          end else if (len_clamp != '0) begin
            state_nxt = ST_COPY;
          end else if (in_word.next_byte != NO_LITERAL) begin
            state_nxt = ST_LIT;
          end
        end
      end
      ST_COPY: begin
        if (slot_free && (cnt_r == LENGTH_W'(1))) begin
          state_nxt = (lit_r != NO_LITERAL) ? ST_LIT : ST_IDLE;
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    bw_nxt        = bw_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    lit_nxt       = lit_r;
    off1_nxt      = off1_r;
    first_nxt     = first_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = copy_byte;
    ram_re        = 1'b0;
    ram_raddr     = src_full[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          wp_nxt    = wp_eff;
          bw_nxt    = bw_eff;
          src_nxt   = src_full[AW-1:0];
          cnt_nxt   = len_clamp;
          lit_nxt   = in_word.next_byte;
          off1_nxt  = (in_word.offset == OFFSET_W'(1));
          first_nxt = 1'b1;
          ram_re    = 1'b1;
        end
      end
      ST_COPY: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.out_byte   = copy_byte;
          out_word_nxt.last       = (cnt_r == LENGTH_W'(1)) && (lit_r == NO_LITERAL);
          out_word_nxt.bad_offset = 1'b0;
          ram_we    = 1'b1;
          wp_nxt    = wp_inc;
          bw_nxt    = bw_inc;
          src_nxt   = src_inc;
          cnt_nxt   = cnt_r - 1'b1;
          hold_nxt  = copy_byte;
          first_nxt = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = src_inc;
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.out_byte   = lit_r;
          out_word_nxt.last       = 1'b1;
          out_word_nxt.bad_offset = 1'b0;
          ram_we    = 1'b1;
          ram_wdata = lit_r;
          wp_nxt    = wp_inc;
          bw_nxt    = bw_inc;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.out_byte   = '0;
          out_word_nxt.last       = 1'b1;
          out_word_nxt.bad_offset = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      bw_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      bw_r        <= bw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cnt_r      <= cnt_nxt;
    lit_r      <= lit_nxt;
    off1_r     <= off1_nxt;
    first_r    <= first_nxt;
    hold_r     <= hold_nxt;
    out_word_r <= out_word_nxt;
  end

  lz77d_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
